@@ hw/rtl/nrc_pkg.sv @@
// Shared constants, codes and types of the nearest reference classifier.
package nrc_pkg;

    localparam int REF_DEPTH = 64;

    localparam int PT_W = 16;
    localparam int ANG_W = 15;
    localparam int TOL_W = 4;
    localparam int CNT_W = 8;
    localparam int DIFF_W = 16;
    localparam int TOLP_W = 20;
    localparam int SQ_W = 30;
    localparam int DIST_W = 31;
    localparam int ENTRY_W = 1 + PT_W + 2 * ANG_W;

    localparam logic [TOL_W-1:0] TOL_RESET = 4'd3;
    localparam logic [DIFF_W-1:0] PI_FIXED = 16'd12868;
    localparam logic [DIFF_W-1:0] TWO_PI_FIXED = 16'd25736;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_CLASSIFY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_best;
        logic rd_en;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_sts;

endpackage

@@ hw/rtl/nrc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module nrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/nrc_ctrl.sv @@
// Controller of the classifier: handshakes, table fill count and scan sequencing.
module nrc_ctrl import nrc_pkg::*; #(
    parameter int DEPTH = REF_DEPTH
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    input  logic [1:0]                                 i_mode,
    output logic                                       o_ready,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output t_cmd                                       o_cmd,
    input  t_sts                                       i_sts,
    output logic                                       o_wr_en,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_wr_addr,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_rd_addr
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic r_out_valid, n_out_valid;
    logic [CW-1:0] idx_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign idx_inc = r_idx + CW'(1);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx = r_idx;
        o_ready = 1'b0;
        o_cmd = '0;
        o_wr_en = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        MODE_LOAD: begin
                            if (r_count < CW'(DEPTH)) begin
                                o_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        MODE_CLASSIFY: begin
                            o_cmd.capture = 1'b1;
                            o_cmd.clear_best = 1'b1;
                            n_idx = '0;
                            n_state = (r_count == '0) ? ST_DRAIN : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_idx = idx_inc;
                if (idx_inc == r_count) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_rd_addr = r_idx[AW-1:0];

endmodule

@@ hw/rtl/nrc_dp.sv @@
// Datapath of the classifier: distance pipeline, nearest tracking and jet counters.
module nrc_dp import nrc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [TOL_W-1:0]        i_cfg_wr_data,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [PT_W-1:0]         i_pt,
    input  logic signed [ANG_W-1:0] i_eta,
    input  logic signed [ANG_W-1:0] i_phi,
    input  logic                    i_last_constituent,
    input  logic [ENTRY_W-1:0]      i_rd_data,
    output logic                    o_is_isr,
    output logic [CNT_W-1:0]        o_scalar_total,
    output logic [CNT_W-1:0]        o_isr_total,
    output logic                    o_jet_done
);

    logic [TOL_W-1:0] r_tol;

    logic [PT_W-1:0] r_q_pt;
    logic signed [ANG_W-1:0] r_q_eta;
    logic signed [ANG_W-1:0] r_q_phi;
    logic r_q_last;

    logic r_v0, r_v1, r_v2, r_v3, r_v4;

    logic r_s1_isr;
    logic [DIFF_W-1:0] r_s1_dpt;
    logic [TOLP_W-1:0] r_s1_tolprod;
    logic signed [DIFF_W-1:0] r_s1_deta;
    logic [DIFF_W-1:0] r_s1_dphi;

    logic r_s2_isr, r_s2_qual;
    logic signed [DIFF_W-1:0] r_s2_deta;
    logic signed [DIFF_W-1:0] r_s2_dphi;

    logic r_s3_isr, r_s3_qual;
    logic [SQ_W-1:0] r_s3_eta_sq;
    logic [SQ_W-1:0] r_s3_phi_sq;

    logic r_s4_isr, r_s4_qual;
    logic [DIST_W-1:0] r_s4_dist;

    logic r_sc_found, r_isr_found;
    logic [DIST_W-1:0] r_sc_best, r_isr_best;

    logic [CNT_W-1:0] r_sc_cnt, r_isr_cnt;
    logic r_out_isr, r_out_last;
    logic [CNT_W-1:0] r_out_sc, r_out_isr_cnt;

    logic ref_isr;
    logic [PT_W-1:0] ref_pt;
    logic signed [ANG_W-1:0] ref_eta, ref_phi;
    logic signed [DIFF_W:0] dpt_s;
    logic signed [DIFF_W-1:0] deta_s, dphi_s;
    logic [TOLP_W-1:0] dpt10;
    logic signed [2*DIFF_W-1:0] eta_sq_full, phi_sq_full;
    logic cls_isr;
    logic [CNT_W-1:0] sc_next, isr_next;

    assign ref_isr = i_rd_data[ENTRY_W-1];
    assign ref_pt = i_rd_data[ENTRY_W-2 -: PT_W];
    assign ref_eta = i_rd_data[2*ANG_W-1 -: ANG_W];
    assign ref_phi = i_rd_data[ANG_W-1:0];

    assign dpt_s = $signed({1'b0, ref_pt}) - $signed({1'b0, r_q_pt});
    assign deta_s = DIFF_W'(ref_eta) - DIFF_W'(r_q_eta);
    assign dphi_s = DIFF_W'(ref_phi) - DIFF_W'(r_q_phi);
    assign dpt10 = {1'b0, r_s1_dpt, 3'b000} + {3'b000, r_s1_dpt, 1'b0};
    assign eta_sq_full = r_s2_deta * r_s2_deta;
    assign phi_sq_full = r_s2_dphi * r_s2_dphi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_sc_found <= 1'b0;
            r_isr_found <= 1'b0;
            r_sc_cnt <= '0;
            r_isr_cnt <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            r_v0 <= i_cmd.rd_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.clear_best) begin
                r_sc_found <= 1'b0;
                r_isr_found <= 1'b0;
            end else if (r_v4 && r_s4_qual) begin
                if (r_s4_isr) begin
                    if (!r_isr_found || (r_s4_dist < r_isr_best)) begin
                        r_isr_found <= 1'b1;
                    end
                end else begin
                    if (!r_sc_found || (r_s4_dist < r_sc_best)) begin
                        r_sc_found <= 1'b1;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_sc_cnt <= r_q_last ? '0 : sc_next;
                r_isr_cnt <= r_q_last ? '0 : isr_next;
            end
        end
    end

    // Best distances are payload; the found flags qualify them.
    always_ff @(posedge i_clk) begin
        if (!i_cmd.clear_best && r_v4 && r_s4_qual) begin
            if (r_s4_isr) begin
                if (!r_isr_found || (r_s4_dist < r_isr_best)) begin
                    r_isr_best <= r_s4_dist;
                end
            end else begin
                if (!r_sc_found || (r_s4_dist < r_sc_best)) begin
                    r_sc_best <= r_s4_dist;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_q_pt <= i_pt;
            r_q_eta <= i_eta;
            r_q_phi <= i_phi;
            r_q_last <= i_last_constituent;
        end

        r_s1_isr <= ref_isr;
        r_s1_dpt <= dpt_s[DIFF_W] ? DIFF_W'(-dpt_s) : DIFF_W'(dpt_s);
        r_s1_tolprod <= TOLP_W'(r_tol) * TOLP_W'(ref_pt);
        r_s1_deta <= deta_s;
        r_s1_dphi <= dphi_s[DIFF_W-1] ? DIFF_W'(-dphi_s) : DIFF_W'(dphi_s);

        r_s2_isr <= r_s1_isr;
        r_s2_qual <= (dpt10 <= r_s1_tolprod);
        r_s2_deta <= r_s1_deta;
        r_s2_dphi <= (r_s1_dphi > PI_FIXED) ? $signed(r_s1_dphi - TWO_PI_FIXED)
                                           : $signed(r_s1_dphi);

        r_s3_isr <= r_s2_isr;
        r_s3_qual <= r_s2_qual;
        r_s3_eta_sq <= eta_sq_full[SQ_W-1:0];
        r_s3_phi_sq <= phi_sq_full[SQ_W-1:0];

        r_s4_isr <= r_s3_isr;
        r_s4_qual <= r_s3_qual;
        r_s4_dist <= DIST_W'(r_s3_eta_sq) + DIST_W'(r_s3_phi_sq);

        if (i_cmd.emit) begin
            r_out_isr <= cls_isr;
            r_out_sc <= sc_next;
            r_out_isr_cnt <= isr_next;
            r_out_last <= r_q_last;
        end
    end

    // An ISR reference wins only when strictly nearer than the best scalar, so a tie goes to the scalar.
    assign cls_isr = r_isr_found && (!r_sc_found || (r_isr_best < r_sc_best));

    always_comb begin
        sc_next = r_sc_cnt;
        isr_next = r_isr_cnt;
        if (cls_isr) begin
            if (r_isr_cnt != CNT_MAX) begin
                isr_next = r_isr_cnt + CNT_W'(1);
            end
        end else begin
            if (r_sc_cnt != CNT_MAX) begin
                sc_next = r_sc_cnt + CNT_W'(1);
            end
        end
    end

    assign o_sts.busy = r_v0 | r_v1 | r_v2 | r_v3 | r_v4;
    assign o_is_isr = r_out_isr;
    assign o_scalar_total = r_out_sc;
    assign o_isr_total = r_out_isr_cnt;
    assign o_jet_done = r_out_last;

endmodule

@@ hw/rtl/nearest_reference_classifier.sv @@
// Top level of the nearest reference classifier.
// A classify transaction reads the reference table through its single read
// port, one loaded reference per cycle, and then drains the distance pipeline;
// when the table is empty it skips the scan. A result still waiting on the
// output can hold the transaction back. The next input transaction is taken
// while a result still waits on the output. Each result carries the class of
// the nearest qualifying reference, scalar when none qualifies, and the
// per-jet counts, which restart after a result that closes the jet.
module nearest_reference_classifier import nrc_pkg::*; #(
    parameter int DEPTH = REF_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [TOL_W-1:0]        i_cfg_wr_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_mode,
    input  logic                    i_ref_is_isr,
    input  logic [PT_W-1:0]         i_pt,
    input  logic signed [ANG_W-1:0] i_eta,
    input  logic signed [ANG_W-1:0] i_phi,
    input  logic                    i_last_constituent,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_is_isr,
    output logic [CNT_W-1:0]        o_scalar_total,
    output logic [CNT_W-1:0]        o_isr_total,
    output logic                    o_jet_done
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd cmd;
    t_sts sts;
    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data, rd_data;

    assign wr_data = {i_ref_is_isr, i_pt, i_eta, i_phi};

    nrc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    nrc_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_mode      (i_mode),
        .o_ready     (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr)
    );

    nrc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_pt               (i_pt),
        .i_eta              (i_eta),
        .i_phi              (i_phi),
        .i_last_constituent (i_last_constituent),
        .i_rd_data          (rd_data),
        .o_is_isr           (o_is_isr),
        .o_scalar_total     (o_scalar_total),
        .o_isr_total        (o_isr_total),
        .o_jet_done         (o_jet_done)
    );

    a_emit_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !sts.busy)
        else $error("Result emitted while the distance pipeline still holds references.");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.busy |-> !o_ready)
        else $error("Input ready while a classification is in flight.");

    a_no_scan_on_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |-> !cmd.rd_en && !sts.busy)
        else $error("Query captured during a table scan.");

    a_emit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_valid)
        else $error("Emitted result not presented on the output.");

endmodule

@@ tb/sv/classification_checker.sv @@
// Checker that predicts and compares the classifications of the nearest reference classifier.
`timescale 1ns / 100ps

module classification_checker import nrc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [TOL_W-1:0]        i_cfg_wr_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [1:0]              i_mode,
    input  logic                    i_ref_is_isr,
    input  logic [PT_W-1:0]         i_pt,
    input  logic signed [ANG_W-1:0] i_eta,
    input  logic signed [ANG_W-1:0] i_phi,
    input  logic                    i_last_constituent,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_is_isr,
    input  logic [CNT_W-1:0]        i_scalar_total,
    input  logic [CNT_W-1:0]        i_isr_total,
    input  logic                    i_jet_done,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic             is_isr;
        logic [CNT_W-1:0] scalar_total;
        logic [CNT_W-1:0] isr_total;
        logic             jet_done;
    } t_classification;

    logic [PT_W-1:0]         ref_pt_mem  [REF_DEPTH];
    logic signed [ANG_W-1:0] ref_eta_mem [REF_DEPTH];
    logic signed [ANG_W-1:0] ref_phi_mem [REF_DEPTH];
    logic                    ref_isr_mem [REF_DEPTH];
    int                      ref_total;
    logic [CNT_W-1:0]        scalar_count;
    logic [CNT_W-1:0]        isr_count;
    logic [TOL_W-1:0]        tolerance;
    t_classification         expected_classes[$];
    int                      fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending = expected_classes.size();

    task automatic report_mismatch(input string what);
        $display("%0t: classification mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic pt_in_tolerance(input logic [PT_W-1:0] ref_pt,
                                             input logic [PT_W-1:0] cand_pt);
        longint diff;
        diff = (ref_pt > cand_pt) ? longint'(ref_pt) - longint'(cand_pt)
                                  : longint'(cand_pt) - longint'(ref_pt);
        return !(diff * 10 > longint'(tolerance) * longint'(ref_pt));
    endfunction

    function automatic longint distance_sq(input int idx,
                                           input logic signed [ANG_W-1:0] eta,
                                           input logic signed [ANG_W-1:0] phi);
        longint d_eta;
        longint d_phi;
        d_eta = longint'(ref_eta_mem[idx]) - longint'(eta);
        d_phi = longint'(ref_phi_mem[idx]) - longint'(phi);
        if (d_phi < 0) begin
            d_phi = -d_phi;
        end
        if (d_phi > longint'(PI_FIXED)) begin
            d_phi = d_phi - longint'(TWO_PI_FIXED);
        end
        return d_eta * d_eta + d_phi * d_phi;
    endfunction

    function automatic logic nearest_class(input logic [PT_W-1:0] pt,
                                           input logic signed [ANG_W-1:0] eta,
                                           input logic signed [ANG_W-1:0] phi);
        logic   found;
        logic   isr;
        longint best;
        longint d_sq;
        found = 1'b0;
        isr = 1'b0;
        best = 0;
        for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < ref_total; i++) begin
                if (int'(ref_isr_mem[i]) != pass || !pt_in_tolerance(ref_pt_mem[i], pt)) begin
                    continue;
                end
                d_sq = distance_sq(i, eta, phi);
                if (!found || d_sq < best) begin
                    found = 1'b1;
                    best = d_sq;
                    isr = (pass == 1);
                end
            end
        end
        return isr;
    endfunction

    always @(posedge i_clk) begin
        t_classification predicted;
        t_classification observed;
        logic            cls;
        if (!i_rst_n) begin
            ref_total = 0;
            scalar_count = '0;
            isr_count = '0;
            tolerance = TOL_RESET;
            expected_classes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                tolerance = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                case (i_mode)
                    MODE_CLEAR: begin
                        ref_total = 0;
                    end
                    MODE_LOAD: begin
                        if (ref_total < REF_DEPTH) begin
                            ref_pt_mem[ref_total] = i_pt;
                            ref_eta_mem[ref_total] = i_eta;
                            ref_phi_mem[ref_total] = i_phi;
                            ref_isr_mem[ref_total] = i_ref_is_isr;
                            ref_total++;
                        end
                    end
                    MODE_CLASSIFY: begin
                        cls = nearest_class(i_pt, i_eta, i_phi);
                        if (cls) begin
                            if (isr_count != CNT_MAX) isr_count++;
                        end else begin
                            if (scalar_count != CNT_MAX) scalar_count++;
                        end
                        predicted.is_isr = cls;
                        predicted.scalar_total = scalar_count;
                        predicted.isr_total = isr_count;
                        predicted.jet_done = i_last_constituent;
                        expected_classes.insert(expected_classes.size(), predicted);
                        if (i_last_constituent) begin
                            scalar_count = '0;
                            isr_count = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                observed = '{i_is_isr, i_scalar_total, i_isr_total, i_jet_done};
                if (expected_classes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %p", observed));
                end else begin
                    predicted = expected_classes.pop_front();
                    if (observed.is_isr !== predicted.is_isr) begin
                        report_mismatch($sformatf("is_isr expected %0d got %0d",
                                                  predicted.is_isr, observed.is_isr));
                    end
                    if (observed.scalar_total !== predicted.scalar_total) begin
                        report_mismatch($sformatf("scalar_total expected %0d got %0d",
                                                  predicted.scalar_total, observed.scalar_total));
                    end
                    if (observed.isr_total !== predicted.isr_total) begin
                        report_mismatch($sformatf("isr_total expected %0d got %0d",
                                                  predicted.isr_total, observed.isr_total));
                    end
                    if (observed.jet_done !== predicted.jet_done) begin
                        report_mismatch($sformatf("jet_done expected %0d got %0d",
                                                  predicted.jet_done, observed.jet_done));
                    end
                end
            end
        end
    end

endmodule

@@ tb/sv/nearest_reference_classifier_tb.sv @@
// Top of the nearest reference classifier testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module nearest_reference_classifier_tb import nrc_pkg::*;;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = REF_DEPTH + 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int CHUNK_ITEMS = 65;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [TOL_W-1:0]        cfg_wr_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              mode;
    logic                    ref_is_isr;
    logic [PT_W-1:0]         pt;
    logic signed [ANG_W-1:0] eta;
    logic signed [ANG_W-1:0] phi;
    logic                    last_constituent;
    logic                    out_valid;
    logic                    out_ready;
    logic                    is_isr;
    logic [CNT_W-1:0]        scalar_total;
    logic [CNT_W-1:0]        isr_total;
    logic                    jet_done;
    int                      fail_count;
    int                      pending;

    int                      send_idle;
    int                      recv_idle;
    int                      item_count;
    int                      cycle_count;
    logic [PT_W-1:0]         pool_pt  [REF_DEPTH];
    logic [ANG_W-1:0]        pool_eta [REF_DEPTH];
    logic [ANG_W-1:0]        pool_phi [REF_DEPTH];
    int                      pool_count;

    nearest_reference_classifier DUT (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .i_valid            (in_valid),
        .o_ready            (in_ready),
        .i_mode             (mode),
        .i_ref_is_isr       (ref_is_isr),
        .i_pt               (pt),
        .i_eta              (eta),
        .i_phi              (phi),
        .i_last_constituent (last_constituent),
        .o_valid            (out_valid),
        .i_ready            (out_ready),
        .o_is_isr           (is_isr),
        .o_scalar_total     (scalar_total),
        .o_isr_total        (isr_total),
        .o_jet_done         (jet_done)
    );

    classification_checker u_class_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_mode             (mode),
        .i_ref_is_isr       (ref_is_isr),
        .i_pt               (pt),
        .i_eta              (eta),
        .i_phi              (phi),
        .i_last_constituent (last_constituent),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_is_isr           (is_isr),
        .i_scalar_total     (scalar_total),
        .i_isr_total        (isr_total),
        .i_jet_done         (jet_done),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_item(input logic [1:0] m, input logic isr_bit, input logic [PT_W-1:0] p,
                             input logic [ANG_W-1:0] e, input logic [ANG_W-1:0] f,
                             input logic last_bit);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        ref_is_isr <= isr_bit;
        pt <= p;
        eta <= e;
        phi <= f;
        last_constituent <= last_bit;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (m != MODE_UNUSED) item_count++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic clear_refs();
        send_item(MODE_CLEAR, 1'($urandom_range(1)), PT_W'($urandom), ANG_W'($urandom),
                  ANG_W'($urandom), 1'($urandom_range(1)));
        pool_count = 0;
    endtask

    function automatic logic [ANG_W-1:0] random_angle();
        logic [ANG_W-1:0] a;
        if ($urandom_range(4) == 0) begin
            a = ANG_W'($urandom);
        end else begin
            a = ANG_W'(int'($urandom_range(25736)) - 12868);
        end
        return a;
    endfunction

    task automatic load_ref(input logic isr_bit, input logic [PT_W-1:0] p,
                            input logic [ANG_W-1:0] e, input logic [ANG_W-1:0] f);
        send_item(MODE_LOAD, isr_bit, p, e, f, 1'($urandom_range(1)));
        if (pool_count < REF_DEPTH) begin
            pool_pt[pool_count] = p;
            pool_eta[pool_count] = e;
            pool_phi[pool_count] = f;
            pool_count++;
        end
    endtask

    task automatic load_random_ref();
        logic [PT_W-1:0] p;
        int              r;
        r = $urandom_range(99);
        if (r < 8) begin
            p = '0;
        end else if (r < 22) begin
            p = PT_W'($urandom);
        end else begin
            p = PT_W'($urandom_range(4000, 200));
        end
        load_ref(1'($urandom_range(1)), p, random_angle(), random_angle());
    endtask

    task automatic send_constituent(input logic last_bit);
        logic [PT_W-1:0]  p;
        logic [ANG_W-1:0] e;
        logic [ANG_W-1:0] f;
        int               idx;
        int               spread;
        if (pool_count == 0 || $urandom_range(9) == 0) begin
            p = PT_W'($urandom);
            e = random_angle();
            f = random_angle();
        end else begin
            idx = $urandom_range(pool_count - 1);
            spread = int'(pool_pt[idx]) / 3 + 1;
            p = PT_W'(int'(pool_pt[idx]) + int'($urandom_range(2 * spread)) - spread);
            e = ANG_W'(int'(pool_eta[idx]) + int'($urandom_range(600)) - 300);
            f = ANG_W'(int'(pool_phi[idx]) + int'($urandom_range(600)) - 300);
            if ($urandom_range(7) == 0) begin
                f = -f;
            end
        end
        send_item(MODE_CLASSIFY, 1'($urandom_range(1)), p, e, f, last_bit);
    endtask

    task automatic run_sequence();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 8) begin
            clear_refs();
        end else if (r < 10) begin
            while (pool_count < REF_DEPTH) load_random_ref();
            repeat ($urandom_range(4, 1)) load_random_ref();
        end else if (r < 32) begin
            if (pool_count > 40) clear_refs();
            repeat ($urandom_range(6, 1)) load_random_ref();
        end else if (r < 38) begin
            send_item(MODE_UNUSED, 1'($urandom_range(1)), PT_W'($urandom), ANG_W'($urandom),
                      ANG_W'($urandom), 1'($urandom_range(1)));
            send_item(MODE_CLASSIFY, 1'($urandom_range(1)), PT_W'($urandom), ANG_W'($urandom),
                      ANG_W'($urandom), 1'($urandom_range(1)));
        end else begin
            n = $urandom_range(10, 1);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(19) == 0) load_random_ref();
                send_constituent(i == n - 1);
            end
            if ($urandom_range(24) == 0) wait_drained();
        end
    endtask

    initial begin
        logic [TOL_W-1:0] tol_plan [4];
        tol_plan = '{4'd0, 4'd15, 4'd10, 4'd5};
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        mode = MODE_CLEAR;
        ref_is_isr = 1'b0;
        pt = '0;
        eta = '0;
        phi = '0;
        last_constituent = 1'b0;
        out_ready = 1'b0;
        cycle_count = 0;
        item_count = 0;
        pool_count = 0;
        send_idle = 36;
        recv_idle = 45;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(MODE_CLASSIFY, 1'b0, 16'd1600, 15'sd0, 15'sd0, 1'b0);
        load_ref(1'b0, 16'd1600, 15'sd0, 15'sd0);
        load_ref(1'b1, 16'd1600, 15'sd200, 15'sd0);
        send_item(MODE_CLASSIFY, 1'b0, 16'd1600, 15'sd100, 15'sd0, 1'b0);
        send_item(MODE_CLASSIFY, 1'b0, 16'd1700, 15'sd150, 15'sd0, 1'b0);
        send_item(MODE_CLASSIFY, 1'b1, 16'd3000, 15'sd150, 15'sd0, 1'b0);
        load_ref(1'b1, 16'd1600, 15'sd0, 15'sd12800);
        send_item(MODE_CLASSIFY, 1'b0, 16'd1600, 15'sd0, -15'sd12800, 1'b0);
        load_ref(1'b1, 16'd0, 15'h4000, 15'h4000);
        send_item(MODE_CLASSIFY, 1'b0, 16'd0, 15'h4000, 15'h4000, 1'b0);
        send_item(MODE_CLASSIFY, 1'b0, 16'hFFFF, 15'h3FFF, 15'h3FFF, 1'b0);
        send_item(MODE_UNUSED, 1'b1, 16'hFFFF, 15'h7FFF, 15'h7FFF, 1'b1);
        send_item(MODE_LOAD, 1'b0, 16'hFFFF, 15'h3FFF, 15'h3FFF, 1'b1);
        send_item(MODE_CLASSIFY, 1'b1, 16'hFFFF, 15'h3FFF, 15'h3FFF, 1'b1);
        send_item(MODE_CLEAR, 1'b1, 16'hFFFF, 15'h7FFF, 15'h7FFF, 1'b1);
        pool_count = 0;
        send_item(MODE_CLASSIFY, 1'b0, 16'd1600, 15'sd0, 15'sd0, 1'b1);
        load_ref(1'b1, 16'd800, -15'sd500, 15'sd700);
        load_ref(1'b0, 16'd800, -15'sd500, 15'sd700);
        send_item(MODE_CLASSIFY, 1'b0, 16'd820, -15'sd400, 15'sd600, 1'b1);

        write_tolerance(4'd15);
        clear_refs();
        load_ref(1'b1, 16'hFFFF, 15'sd0, 15'sd0);
        for (int i = 0; i < 258; i++) begin
            send_item(MODE_CLASSIFY, 1'b0, PT_W'($urandom), ANG_W'($urandom), ANG_W'($urandom),
                      i == 257);
        end
        clear_refs();
        for (int i = 0; i < 258; i++) begin
            send_item(MODE_CLASSIFY, 1'b1, PT_W'($urandom), ANG_W'($urandom), ANG_W'($urandom),
                      i == 257);
        end

        for (int chunk = 0; chunk < 4; chunk++) begin
            int target;
            if (chunk == 1) begin
                send_idle = 45;
                recv_idle = 36;
            end else if (chunk >= 2) begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_tolerance(tol_plan[chunk]);
            target = item_count + CHUNK_ITEMS;
            while (item_count < target) run_sequence();
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
